// ===== hdl/gzhc_pkg.sv =====
// Package with the payload types, status codes and CRC32 step of the gzip framing checker.
package gzhc_pkg;

  typedef enum logic [1:0] {
    CMD_CONTAINER = 2'd0,
    CMD_PAYLOAD   = 2'd1,
    CMD_END       = 2'd2,
    CMD_RESTART   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } gzhc_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] mod_time;
    logic [7:0]  extra_flags;
    logic [7:0]  os_code;
    logic        text_flag;
  } gzhc_out_t;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } gzhc_item_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_HDR_DONE = 4'd1;
  localparam logic [3:0] ST_MEMBER   = 4'd2;
  localparam logic [3:0] ST_BAD_ID1  = 4'd3;
  localparam logic [3:0] ST_BAD_ID2  = 4'd4;
  localparam logic [3:0] ST_BAD_CM   = 4'd5;
  localparam logic [3:0] ST_RSV_FLG  = 4'd6;
  localparam logic [3:0] ST_HCRC     = 4'd7;
  localparam logic [3:0] ST_DCRC     = 4'd8;
  localparam logic [3:0] ST_SIZE     = 4'd9;
  localparam logic [3:0] ST_SEQ      = 4'd10;

  localparam logic [7:0]  ID1_BYTE  = 8'h1F;
  localparam logic [7:0]  ID2_BYTE  = 8'h8B;
  localparam logic [7:0]  CM_DEFL   = 8'd8;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/gzip_member_header_trailer_checker.sv =====
// Top level of the gzip member framing checker: front queue and checking engine.
// A result reaches the result ports after its input is registered in the front queue and then in the
// engine's result queue. Throughput: one item per cycle while the result queue has room; the CRC32 byte
// step and the header state step are combinational, limited by the eight-bit CRC update logic.
// Reset (rst_ni, asynchronous, active low) empties both queues and returns the
// parser to the first ID byte with the CRC preset to all ones.
module gzip_member_header_trailer_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  gzhc_pkg::gzhc_in_t  item_i,
  output logic                empty,
  input  logic                pop,
  output gzhc_pkg::gzhc_out_t result_o
);
  import gzhc_pkg::*;

  gzhc_item_t item;
  logic       valid, take;

  gzhc_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i,
    .valid_o(valid), .take_i(take), .item_o(item)
  );

  gzhc_engine u_engine (
    .clk_i, .rst_ni, .valid_i(valid), .take_o(take), .item_i(item),
    .empty, .pop, .result_o
  );

endmodule

// ===== hdl/gzhc_front.sv =====
// Front end: accepts input transfers, classifies them and holds them in a two-entry queue.
module gzhc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  gzhc_pkg::gzhc_in_t  item_i,
  output logic                valid_o,
  input  logic                take_i,
  output gzhc_pkg::gzhc_item_t item_o
);
  import gzhc_pkg::*;

  gzhc_item_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign wr      = push && !full;
  assign rd      = take_i && valid_o;
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= !wptr_q;
      if (rd) rptr_q <= !rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= '{kind: cmd_e'(item_i.cmd), data: item_i.data_byte};
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("front queue overfilled");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !take_i) |=> full)
    else $error("front queue lost an entry");
  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> valid_o)
    else $error("accepted transfer not visible to the engine");

endmodule

// ===== hdl/gzhc_engine.sv =====
// Back end: header, payload and trailer checking, with a two-entry result queue.
module gzhc_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 take_o,
  input  gzhc_pkg::gzhc_item_t item_i,
  output logic                 empty,
  input  logic                 pop,
  output gzhc_pkg::gzhc_out_t  result_o
);
  import gzhc_pkg::*;

  localparam logic [3:0] PH_ID1 = 4'd0, PH_ID2 = 4'd1, PH_CM = 4'd2, PH_FLG = 4'd3;
  localparam logic [3:0] PH_MTIME = 4'd4, PH_XFL = 4'd5, PH_OS = 4'd6, PH_XLEN = 4'd7;
  localparam logic [3:0] PH_EXTRA = 4'd8, PH_NAME = 4'd9, PH_COMMENT = 4'd10;
  localparam logic [3:0] PH_HCRC = 4'd11, PH_PAYLOAD = 4'd12, PH_TRAILER = 4'd13;
  localparam logic [3:0] PH_DONE = 4'd14, PH_ERROR = 4'd15;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] fc_q, fc_d, xlen_q, xlen_d;
  logic [31:0] fs_q, fs_d, crc_q, crc_d, cnt_q, cnt_d, time_q, time_d;
  logic [3:0]  opt_q, opt_d;
  logic [7:0]  xfl_q, xfl_d, os_q, os_d;
  logic        text_q, text_d;
  logic [3:0]  st;
  logic        do_adv;
  logic [3:0]  adv_from;
  logic [3:0]  adv_ph;
  logic [31:0] shifted;
  logic [16:0] fc_inc;
  logic [7:0]  b;

  gzhc_out_t  oq_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       opop;

  // Options: bit 0 header CRC, bit 1 extra, bit 2 name, bit 3 comment.
  function automatic logic [3:0] next_section(input logic [3:0] opt, input logic [3:0] from);
    if (opt[1] && from < PH_XLEN)    return PH_XLEN;
    if (opt[2] && from < PH_NAME)    return PH_NAME;
    if (opt[3] && from < PH_COMMENT) return PH_COMMENT;
    if (opt[0] && from < PH_HCRC)    return PH_HCRC;
    return PH_PAYLOAD;
  endfunction

  assign take_o  = valid_i && (ocnt_q != 2'd2);
  assign b       = item_i.data;
  assign shifted = fs_q | ({24'd0, b} << {fc_q[1:0], 3'b000});
  assign fc_inc  = {1'b0, fc_q} + 17'd1;
  assign adv_ph  = next_section(opt_q, adv_from);

  always_comb begin
    phase_d = phase_q; fc_d = fc_q; xlen_d = xlen_q; fs_d = fs_q; crc_d = crc_q;
    cnt_d = cnt_q; opt_d = opt_q; time_d = time_q; xfl_d = xfl_q; os_d = os_q;
    text_d = text_q; st = ST_OK; do_adv = 1'b0; adv_from = phase_q;
    if (take_o) begin
      if (phase_q == PH_ERROR) begin
        st = fc_q[3:0];
      end else begin
        case (item_i.kind)
          CMD_CONTAINER: begin
            if (phase_q <= PH_COMMENT) crc_d = crc_byte(crc_q, b);
            case (phase_q)
              PH_ID1: begin
                if (b != ID1_BYTE) st = ST_BAD_ID1;
                else phase_d = PH_ID2;
              end
              PH_ID2: begin
                if (b != ID2_BYTE) st = ST_BAD_ID2;
                else phase_d = PH_CM;
              end
              PH_CM: begin
                if (b != CM_DEFL) st = ST_BAD_CM;
                else phase_d = PH_FLG;
              end
              PH_FLG: begin
                text_d = b[0];
                opt_d  = b[4:1];
                if (b[7:5] != 3'd0) st = ST_RSV_FLG;
                else begin
                  phase_d = PH_MTIME; fc_d = '0; fs_d = '0;
                end
              end
              PH_MTIME: begin
                fs_d = shifted;
                if (fc_q == 16'd3) begin
                  time_d = shifted; phase_d = PH_XFL; fc_d = '0;
                end else fc_d = fc_inc[15:0];
              end
              PH_XFL: begin
                xfl_d = b; phase_d = PH_OS;
              end
              PH_OS: begin
                os_d = b; do_adv = 1'b1;
              end
              PH_XLEN: begin
                if (fc_q == 16'd0) begin
                  fs_d = {24'd0, b}; fc_d = 16'd1;
                end else begin
                  xlen_d = {b, fs_q[7:0]};
                  if ({b, fs_q[7:0]} == 16'd0) begin
                    do_adv = 1'b1; adv_from = PH_EXTRA;
                  end else begin
                    phase_d = PH_EXTRA; fc_d = '0;
                  end
                end
              end
              PH_EXTRA: begin
                if (fc_inc >= {1'b0, xlen_q}) do_adv = 1'b1;
                else fc_d = fc_inc[15:0];
              end
              PH_NAME, PH_COMMENT: begin
                if (b == 8'd0) do_adv = 1'b1;
              end
              PH_HCRC: begin
                if (fc_q == 16'd0) begin
                  fs_d = {24'd0, b}; fc_d = 16'd1;
                end else if ({b, fs_q[7:0]} != ~crc_q[15:0]) st = ST_HCRC;
                else do_adv = 1'b1;
              end
              PH_TRAILER: begin
                fs_d = shifted;
                fc_d = fc_inc[15:0];
                if (fc_q == 16'd3) begin
                  if (shifted != ~crc_q) st = ST_DCRC;
                  else fs_d = '0;
                end else if (fc_q == 16'd7) begin
                  if (shifted != cnt_q) st = ST_SIZE;
                  else begin
                    phase_d = PH_DONE; fc_d = '0; st = ST_MEMBER;
                  end
                end
              end
              default: st = ST_SEQ;
            endcase
          end
          CMD_PAYLOAD: begin
            if (phase_q != PH_PAYLOAD) st = ST_SEQ;
            else begin
              crc_d = crc_byte(crc_q, b); cnt_d = cnt_q + 32'd1;
            end
          end
          CMD_END: begin
            if (phase_q != PH_PAYLOAD) st = ST_SEQ;
            else begin
              phase_d = PH_TRAILER; fc_d = '0; fs_d = '0;
            end
          end
          default: begin
            if (phase_q != PH_DONE) st = ST_SEQ;
            else begin
              phase_d = PH_ID1; fc_d = '0; fs_d = '0; crc_d = CRC_INIT;
            end
          end
        endcase
        if (do_adv) begin
          fc_d = '0; fs_d = '0; phase_d = adv_ph;
          if (adv_ph == PH_PAYLOAD) begin
            crc_d = CRC_INIT; cnt_d = '0; st = ST_HDR_DONE;
          end
        end
        // Every failure code lands here; the code is kept in the field counter.
        if (st >= ST_BAD_ID1) begin
          phase_d = PH_ERROR; fc_d = {12'd0, st};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID1; fc_q <= '0; xlen_q <= '0; fs_q <= '0; crc_q <= CRC_INIT;
      cnt_q <= '0; opt_q <= '0; time_q <= '0; xfl_q <= 8'd3; os_q <= 8'd255;
      text_q <= 1'b0;
    end else begin
      phase_q <= phase_d; fc_q <= fc_d; xlen_q <= xlen_d; fs_q <= fs_d; crc_q <= crc_d;
      cnt_q <= cnt_d; opt_q <= opt_d; time_q <= time_d; xfl_q <= xfl_d; os_q <= os_d;
      text_q <= text_d;
    end
  end

  assign empty    = (ocnt_q == 2'd0);
  assign opop     = pop && !empty;
  assign result_o = oq_q[orp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q <= 1'b0; orp_q <= 1'b0; ocnt_q <= 2'd0;
    end else begin
      if (take_o) owp_q <= !owp_q;
      if (opop) orp_q <= !orp_q;
      ocnt_q <= ocnt_q + {1'b0, take_o} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      oq_q[owp_q] <= '{status: st, mod_time: time_d, extra_flags: xfl_d,
                       os_code: os_d, text_flag: text_d};
    end
  end

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |=> phase_q == PH_ERROR && $stable(fc_q))
    else $error("error phase left");
  a_ocnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) ocnt_q <= 2'd2)
    else $error("result queue overfilled");
  a_take_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q == 2'd2) |-> !take_o)
    else $error("item taken without result room");

endmodule

// ===== dv/gzip_member_header_trailer_checker_tb.sv =====
// Testbench for the gzip member framing checker: predicts each status and header field, compares in order.
module gzip_member_header_trailer_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gzhc_pkg::*;

  typedef enum logic [3:0] {
    P_ID1, P_ID2, P_CM, P_FLG, P_MTIME, P_XFL, P_OS, P_XLEN, P_EXTRA, P_NAME,
    P_COMMENT, P_HCRC, P_PAYLOAD, P_TRAILER, P_DONE, P_ERROR
  } gz_phase_e;

  localparam logic [3:0] OPT_HCRC    = 4'd1;
  localparam logic [3:0] OPT_EXTRA   = 4'd2;
  localparam logic [3:0] OPT_NAME    = 4'd4;
  localparam logic [3:0] OPT_COMMENT = 4'd8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  gzhc_in_t item_i = '0;
  gzhc_out_t result_o;

  gzip_member_header_trailer_checker dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .result_o(result_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state.
  gz_phase_e   m_phase;
  logic [15:0] m_count, m_xlen;
  logic [31:0] m_shift, m_crc, m_size, m_time;
  logic [3:0]  m_opts;
  logic [7:0]  m_xfl, m_os;
  logic        m_text;

  gzhc_in_t  pending_items[$];
  gzhc_out_t expected_status[$];
  int errors = 0;
  int mismatches = 0;
  bit hold_off = 1'b0;

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  task automatic predictor_reset();
    m_phase = P_ID1; m_count = '0; m_xlen = '0; m_shift = '0; m_crc = '1;
    m_size = '0; m_opts = '0; m_time = '0; m_xfl = 8'd3; m_os = 8'hFF; m_text = 1'b0;
  endtask

  function automatic logic [3:0] raise_error(logic [3:0] code);
    m_phase = P_ERROR;
    m_count = {12'd0, code};
    return code;
  endfunction

  // Moves on to the next optional section present after the given one, or to the payload when none is left.
  function automatic logic [3:0] next_section(gz_phase_e from);
    m_count = '0;
    m_shift = '0;
    if ((m_opts & OPT_EXTRA) != 0 && from < P_XLEN) begin
      m_phase = P_XLEN; return ST_OK;
    end
    if ((m_opts & OPT_NAME) != 0 && from < P_NAME) begin
      m_phase = P_NAME; return ST_OK;
    end
    if ((m_opts & OPT_COMMENT) != 0 && from < P_COMMENT) begin
      m_phase = P_COMMENT; return ST_OK;
    end
    if ((m_opts & OPT_HCRC) != 0 && from < P_HCRC) begin
      m_phase = P_HCRC; return ST_OK;
    end
    m_phase = P_PAYLOAD;
    m_crc = '1;
    m_size = '0;
    return ST_HDR_DONE;
  endfunction

  function automatic logic [3:0] container_step(logic [7:0] b);
    gz_phase_e p;
    logic [31:0] sh;
    p = m_phase;
    sh = {24'd0, b} << (8 * m_count[1:0]);
    if (p <= P_COMMENT) m_crc = crc_step(m_crc, b);
    case (p)
      P_ID1: begin
        if (b != ID1_BYTE) return raise_error(ST_BAD_ID1);
        m_phase = P_ID2; return ST_OK;
      end
      P_ID2: begin
        if (b != ID2_BYTE) return raise_error(ST_BAD_ID2);
        m_phase = P_CM; return ST_OK;
      end
      P_CM: begin
        if (b != CM_DEFL) return raise_error(ST_BAD_CM);
        m_phase = P_FLG; return ST_OK;
      end
      P_FLG: begin
        m_text = b[0];
        m_opts = b[4:1];
        if (b[7:5] != 0) return raise_error(ST_RSV_FLG);
        m_phase = P_MTIME; m_count = '0; m_shift = '0; return ST_OK;
      end
      P_MTIME: begin
        m_shift |= sh;
        if (m_count == 16'd3) begin
          m_time = m_shift; m_phase = P_XFL; m_count = '0;
        end else begin
          m_count++;
        end
        return ST_OK;
      end
      P_XFL: begin
        m_xfl = b; m_phase = P_OS; return ST_OK;
      end
      P_OS: begin
        m_os = b; return next_section(P_OS);
      end
      P_XLEN: begin
        if (m_count == 0) begin
          m_shift = {24'd0, b}; m_count = 16'd1; return ST_OK;
        end
        m_xlen = {b, m_shift[7:0]};
        if (m_xlen == 0) return next_section(P_EXTRA);
        m_phase = P_EXTRA; m_count = '0; return ST_OK;
      end
      P_EXTRA: begin
        if ({1'b0, m_count} + 17'd1 >= {1'b0, m_xlen}) return next_section(P_EXTRA);
        m_count++;
        return ST_OK;
      end
      P_NAME, P_COMMENT: begin
        if (b == 0) return next_section(p);
        return ST_OK;
      end
      P_HCRC: begin
        if (m_count == 0) begin
          m_shift = {24'd0, b}; m_count = 16'd1; return ST_OK;
        end
        if ({b, m_shift[7:0]} != ~m_crc[15:0]) return raise_error(ST_HCRC);
        return next_section(P_HCRC);
      end
      P_TRAILER: begin
        m_shift |= sh;
        if (m_count == 16'd3) begin
          if (m_shift != ~m_crc) return raise_error(ST_DCRC);
          m_shift = '0;
        end else if (m_count == 16'd7) begin
          if (m_shift != m_size) return raise_error(ST_SIZE);
          m_phase = P_DONE; m_count = '0; return ST_MEMBER;
        end
        m_count++;
        return ST_OK;
      end
      default: return raise_error(ST_SEQ);
    endcase
  endfunction

  function automatic gzhc_out_t predict_status(gzhc_in_t it);
    gzhc_out_t r;
    logic [3:0] st;
    if (m_phase == P_ERROR) begin
      st = m_count[3:0];
    end else begin
      case (cmd_e'(it.cmd))
        CMD_CONTAINER: st = (m_phase == P_PAYLOAD) ? raise_error(ST_SEQ)
                                                   : container_step(it.data_byte);
        CMD_PAYLOAD: begin
          if (m_phase != P_PAYLOAD) begin
            st = raise_error(ST_SEQ);
          end else begin
            m_crc = crc_step(m_crc, it.data_byte); m_size++; st = ST_OK;
          end
        end
        CMD_END: begin
          if (m_phase != P_PAYLOAD) begin
            st = raise_error(ST_SEQ);
          end else begin
            m_phase = P_TRAILER; m_count = '0; m_shift = '0; st = ST_OK;
          end
        end
        default: begin
          if (m_phase != P_DONE) begin
            st = raise_error(ST_SEQ);
          end else begin
            m_phase = P_ID1; m_count = '0; m_shift = '0; m_crc = '1; st = ST_OK;
          end
        end
      endcase
    end
    r.status = st; r.mod_time = m_time; r.extra_flags = m_xfl;
    r.os_code = m_os; r.text_flag = m_text;
    return r;
  endfunction

  // Stimulus helpers, building byte streams of whole members.
  function automatic gzhc_in_t mk(cmd_e c, logic [7:0] b);
    gzhc_in_t it;
    it.cmd = c; it.data_byte = b;
    return it;
  endfunction

  task automatic queue_hdr_byte(logic [7:0] b, inout logic [31:0] hcrc);
    pending_items.push_back(mk(CMD_CONTAINER, b));
    hcrc = crc_step(hcrc, b);
  endtask

  // One well-formed member; corrupt selects an optional fault:
  // 0 none, 1 bad header crc, 2 bad data crc, 3 bad size, 4 early restart.
  task automatic queue_member(logic [7:0] flg, int plen, int corrupt, logic [15:0] xlen);
    logic [31:0] hc, dc, mt;
    logic [7:0] b;
    int n;
    hc = '1; dc = '1; mt = $urandom;
    queue_hdr_byte(ID1_BYTE, hc);
    queue_hdr_byte(ID2_BYTE, hc);
    queue_hdr_byte(CM_DEFL, hc);
    queue_hdr_byte(flg, hc);
    for (int i = 0; i < 4; i++) queue_hdr_byte(mt[8*i +: 8], hc);
    queue_hdr_byte(8'($urandom), hc);
    queue_hdr_byte(8'($urandom), hc);
    if (flg[2]) begin
      queue_hdr_byte(xlen[7:0], hc);
      queue_hdr_byte(xlen[15:8], hc);
      for (int i = 0; i < xlen; i++) queue_hdr_byte(8'($urandom), hc);
    end
    for (int s = 0; s < 2; s++) begin
      if ((s == 0 && flg[3]) || (s == 1 && flg[4])) begin
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) queue_hdr_byte(8'($urandom_range(1, 255)), hc);
        queue_hdr_byte(8'h00, hc);
      end
    end
    if (flg[1]) begin
      hc = ~hc;
      if (corrupt == 1) hc[$urandom_range(0, 15)] ^= 1'b1;
      pending_items.push_back(mk(CMD_CONTAINER, hc[7:0]));
      pending_items.push_back(mk(CMD_CONTAINER, hc[15:8]));
    end
    if (corrupt == 4) pending_items.push_back(mk(CMD_RESTART, 8'($urandom)));
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      dc = crc_step(dc, b);
      pending_items.push_back(mk(CMD_PAYLOAD, b));
    end
    pending_items.push_back(mk(CMD_END, 8'($urandom)));
    dc = ~dc;
    if (corrupt == 2) dc[$urandom_range(0, 31)] ^= 1'b1;
    for (int i = 0; i < 4; i++) pending_items.push_back(mk(CMD_CONTAINER, dc[8*i +: 8]));
    mt = 32'(plen);
    if (corrupt == 3) mt[$urandom_range(0, 31)] ^= 1'b1;
    for (int i = 0; i < 4; i++) pending_items.push_back(mk(CMD_CONTAINER, mt[8*i +: 8]));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_status.size() != 0) @(posedge clk_i);
  endtask

  // Driver: bursts of transfers with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_items.size() != 0) begin
        push <= 1'b1;
        item_i <= pending_items[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        push <= 1'b0;
        item_i <= 10'($urandom);
      end
    end
  end

  // Transfer accepted at the rising edge: predict it then.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      expected_status.push_back(predict_status(item_i));
      void'(pending_items.pop_front());
    end
  end

  // Receiver stall pattern.
  int stall_phase = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      pop <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 23;
      pop <= (stall_phase < 12) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    @(posedge rst_ni);
    repeat (40) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Monitor.
  gzhc_out_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_status.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", result_o);
      end else begin
        exp_r = expected_status.pop_front();
        if (result_o !== exp_r) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch: status exp %0d got %0d, mtime exp %h got %h, ",
                      "xfl exp %h got %h, os exp %h got %h, text exp %b got %b"},
                     exp_r.status, result_o.status, exp_r.mod_time, result_o.mod_time,
                     exp_r.extra_flags, result_o.extra_flags, exp_r.os_code,
                     result_o.os_code, exp_r.text_flag, result_o.text_flag);
        end
      end
    end
  end

  // Main sequence. Errors are sticky, so a faulty case ends the run and the
  // block is only reset once; the one faulty case therefore runs last.
  initial begin
    int sel;
    predictor_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: all options, two extra bytes; restart; plain member; restart; empty extra field.
    queue_member(8'h1F, 3, 0, 16'd2);
    pending_items.push_back(mk(CMD_RESTART, 8'hFF));
    queue_member(8'h00, 0, 0, 16'd0);
    pending_items.push_back(mk(CMD_RESTART, 8'h00));
    queue_member(8'h04, 1, 0, 16'd0);

    for (int m = 0; m < 3; m++) begin
      pending_items.push_back(mk(CMD_RESTART, 8'($urandom)));
      queue_member({3'b000, 5'($urandom)}, $urandom_range(0, 12), 0,
                   16'($urandom_range(0, 3)));
    end

    // Random well-formed members.
    while (pending_items.size() < 1100) begin
      pending_items.push_back(mk(CMD_RESTART, 8'($urandom)));
      queue_member({3'b000, 5'($urandom)}, $urandom_range(0, 30), 0,
                   ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
                                                : 16'($urandom_range(0, 3)));
    end
    wait_drained();

    // Faulty ending: one random fault kind, then random noise over the sticky error.
    sel = $urandom_range(0, 8);
    pending_items.push_back(mk(CMD_RESTART, 8'($urandom)));
    case (sel)
      0: pending_items.push_back(mk(CMD_CONTAINER, 8'h1E));
      1: begin
        pending_items.push_back(mk(CMD_CONTAINER, ID1_BYTE));
        pending_items.push_back(mk(CMD_CONTAINER, 8'h8A));
      end
      2: begin
        pending_items.push_back(mk(CMD_CONTAINER, ID1_BYTE));
        pending_items.push_back(mk(CMD_CONTAINER, ID2_BYTE));
        pending_items.push_back(mk(CMD_CONTAINER, 8'h07));
      end
      3: queue_member(8'hE0 | 8'($urandom_range(0, 31)), 2, 0, 16'd0);
      4: queue_member(8'h02, 2, 1, 16'd0);
      5: queue_member(8'h00, 5, 2, 16'd0);
      6: queue_member(8'h00, 5, 3, 16'd0);
      7: queue_member(8'h00, 5, 4, 16'd0);
      default: pending_items.push_back(mk(CMD_PAYLOAD, 8'($urandom)));
    endcase
    for (int i = 0; i < 150; i++)
      pending_items.push_back(mk(cmd_e'(2'($urandom_range(0, 3))), 8'($urandom)));
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gzhc_pkg.sv
hdl/gzhc_front.sv
hdl/gzhc_engine.sv
hdl/gzip_member_header_trailer_checker.sv
dv/gzip_member_header_trailer_checker_tb.sv
